### design/uct_pkg.sv
// shared types and constants for the utf-8 character-class tokenizer
// no dependencies; used by every module of the block by scoped names
package uct_pkg;

	// token kind codes, as carried on the result port
	typedef enum logic [1:0] {
		KIND_SPACE  = 2'd0,
		KIND_SYMBOL = 2'd1,
		KIND_NUMBER = 2'd2,
		KIND_WORD   = 2'd3
	} kind_t;

	// decimal point code after reset ('.')
	localparam logic [6:0] DEFAULT_POINT = 7'd46;

	// byte classes for the front-end decode
	localparam logic [7:0] BLANK_TOP = 8'd32;
	localparam logic [7:0] DEL_CODE  = 8'd127;

	// one classified byte, passed from front end to back end
	typedef struct packed {
		logic       is_ascii;   // byte below 0x80
		logic       is_cont;    // byte is 10xxxxxx
		logic [1:0] lead_owe;   // continuation bytes a lead byte asks for
		kind_t      cls;        // ascii class, valid when is_ascii
		logic       is_point;   // byte is the decimal point code and a symbol
		logic       eot;        // last byte of the text
	} item_t;

endpackage

### design/uct_front.sv
// front end: decimal point register and per-byte classification
// depends on uct_pkg
module uct_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [6:0]        cfg_data,
	input  logic [7:0]        text_byte,
	input  logic              end_of_text,
	output uct_pkg::item_t    item
);

	logic [6:0]     point_q;
	uct_pkg::kind_t cls;

	// configuration register, always ready
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			point_q <= uct_pkg::DEFAULT_POINT;
		end else if (cfg_valid) begin
			point_q <= cfg_data;
		end
	end

	// ascii character class
	always_comb begin
		if (text_byte <= uct_pkg::BLANK_TOP || text_byte == uct_pkg::DEL_CODE) begin
			cls = uct_pkg::KIND_SPACE;
		end else if (text_byte >= 8'd48 && text_byte <= 8'd57) begin
			cls = uct_pkg::KIND_NUMBER;
		end else if ((text_byte >= 8'd65 && text_byte <= 8'd90) ||
		             (text_byte >= 8'd97 && text_byte <= 8'd122)) begin
			cls = uct_pkg::KIND_WORD;
		end else begin
			cls = uct_pkg::KIND_SYMBOL;
		end
	end

	// utf-8 lead byte decode and item assembly
	always_comb begin
		item          = '0;
		item.is_ascii = ~text_byte[7];
		item.is_cont  = (text_byte[7:6] == 2'b10);
		item.cls      = cls;
		item.is_point = ~text_byte[7] && (text_byte[6:0] == point_q) &&
		                (cls == uct_pkg::KIND_SYMBOL);
		item.eot      = end_of_text;
		if (text_byte[7:5] == 3'b110) begin
			item.lead_owe = 2'd1;
		end else if (text_byte[7:4] == 4'b1110) begin
			item.lead_owe = 2'd2;
		end else if (text_byte[7:3] == 5'b11110) begin
			item.lead_owe = 2'd3;
		end else begin
			item.lead_owe = 2'd0;
		end
	end

endmodule

### design/uct_queue.sv
// short fifo of classified bytes between front end and back end
// depends on uct_pkg
module uct_queue #(
	parameter int DEPTH = 2
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  uct_pkg::item_t push_item,
	output logic           full,
	input  logic           pop,
	output logic           not_empty,
	output uct_pkg::item_t head_item
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	uct_pkg::item_t  slot_q [DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [CW-1:0]   count_q;

	assign full      = (count_q == CW'(DEPTH));
	assign not_empty = (count_q != '0);
	assign head_item = slot_q[rd_ptr_q];

	// pointer and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// payload slots
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

### design/uct_back.sv
// back end: token run state, boundary marks and the result register
// depends on uct_pkg
module uct_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           item_valid,
	input  uct_pkg::item_t item,
	output logic           item_take,
	output logic           out_valid,
	input  logic           out_ready,
	output logic [1:0]     token_kind,
	output logic           starts_token,
	output logic           truncated_char
);

	uct_pkg::kind_t open_kind_q, open_kind_d;
	logic           token_open_q, token_open_d;
	logic           point_seen_q, point_seen_d;
	logic [1:0]     cont_left_q, cont_left_d;
	uct_pkg::kind_t kind_d;
	logic           start_d;
	logic           trunc_d;
	logic           merges;

	logic           out_valid_q;
	uct_pkg::kind_t kind_q;
	logic           start_q;
	logic           trunc_q;

	// take a beat when the result register is free or being drained
	assign item_take = item_valid && (!out_valid_q || out_ready);

	assign merges = token_open_q && (open_kind_q != uct_pkg::KIND_SYMBOL);

	// run merge and continuation tracking
	always_comb begin
		open_kind_d  = open_kind_q;
		token_open_d = token_open_q;
		point_seen_d = point_seen_q;
		cont_left_d  = cont_left_q;
		kind_d       = uct_pkg::KIND_SYMBOL;
		start_d      = 1'b1;
		trunc_d      = 1'b0;
		if (cont_left_q != 2'd0 && item.is_cont) begin
			// owed continuation byte stays with its character
			kind_d      = uct_pkg::KIND_SYMBOL;
			start_d     = 1'b0;
			cont_left_d = cont_left_q - 2'd1;
		end else if (!item.is_ascii) begin
			// lead, stray or invalid byte opens a symbol token
			kind_d       = uct_pkg::KIND_SYMBOL;
			start_d      = 1'b1;
			cont_left_d  = item.lead_owe;
			open_kind_d  = uct_pkg::KIND_SYMBOL;
			token_open_d = 1'b1;
			point_seen_d = 1'b0;
		end else begin
			cont_left_d = 2'd0;
			if (merges && item.cls == open_kind_q) begin
				kind_d  = item.cls;
				start_d = 1'b0;
			end else if (merges && open_kind_q == uct_pkg::KIND_NUMBER &&
			             item.is_point && !point_seen_q) begin
				kind_d       = uct_pkg::KIND_NUMBER;
				start_d      = 1'b0;
				point_seen_d = 1'b1;
			end else begin
				kind_d       = item.cls;
				start_d      = 1'b1;
				open_kind_d  = item.cls;
				token_open_d = 1'b1;
				point_seen_d = 1'b0;
			end
		end
		// end of text closes everything
		if (item.eot) begin
			trunc_d      = (cont_left_d != 2'd0);
			open_kind_d  = uct_pkg::KIND_SPACE;
			token_open_d = 1'b0;
			point_seen_d = 1'b0;
			cont_left_d  = 2'd0;
		end
	end

	// tokenizer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_kind_q  <= uct_pkg::KIND_SPACE;
			token_open_q <= 1'b0;
			point_seen_q <= 1'b0;
			cont_left_q  <= 2'd0;
		end else if (item_take) begin
			open_kind_q  <= open_kind_d;
			token_open_q <= token_open_d;
			point_seen_q <= point_seen_d;
			cont_left_q  <= cont_left_d;
		end
	end

	// result register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (item_take) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (item_take) begin
			kind_q  <= kind_d;
			start_q <= start_d;
			trunc_q <= trunc_d;
		end
	end

	assign out_valid      = out_valid_q;
	assign token_kind     = kind_q;
	assign starts_token   = start_q;
	assign truncated_char = trunc_q;

endmodule

### design/utf8_char_class_tokenizer.sv
// top level of the utf-8 character-class tokenizer
// depends on uct_pkg, uct_front, uct_queue, uct_back
//
// Takes one text byte per beat and returns one result beat per byte: the kind of
// token the byte belongs to, a start-of-token mark, and on the last byte of a text
// a flag when a multi-byte character was left unfinished. Sustained rate is one
// byte per clock while out_ready stays high and QUEUE_DEPTH is at least 2; a byte
// is registered in the fifo and then in the result register before it is output.
// The front end classifies each byte and writes it into a QUEUE_DEPTH-entry fifo;
// the back end holds the run state, updated once per byte taken from the fifo,
// and a result register. Input ready drops only when the fifo is full, so the two
// sides stall independently. The decimal point register may be written only while
// no byte is in flight.
module utf8_char_class_tokenizer #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [6:0] cfg_data,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] text_byte,
	input  logic       end_of_text,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [1:0] token_kind,
	output logic       starts_token,
	output logic       truncated_char
);

	uct_pkg::item_t front_item;
	uct_pkg::item_t head_item;
	logic           q_full;
	logic           q_not_empty;
	logic           q_pop;

	assign in_ready = !q_full;

	// byte classification and configuration
	uct_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_data    (cfg_data),
		.text_byte   (text_byte),
		.end_of_text (end_of_text),
		.item        (front_item)
	);

	// decoupling fifo
	uct_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (in_valid && !q_full),
		.push_item (front_item),
		.full      (q_full),
		.pop       (q_pop),
		.not_empty (q_not_empty),
		.head_item (head_item)
	);

	// token state and result register
	uct_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.item_valid     (q_not_empty),
		.item           (head_item),
		.item_take      (q_pop),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.token_kind     (token_kind),
		.starts_token   (starts_token),
		.truncated_char (truncated_char)
	);

endmodule
